/* src/round_robin_expedite_queue_core_macros.svh */
// assertion macros used by the checker file
`ifndef ROUND_ROBIN_EXPEDITE_QUEUE_CORE_MACROS_SVH
`define ROUND_ROBIN_EXPEDITE_QUEUE_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define RREQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RREQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rreq_pkg.sv */
// shared constants and types of the expedite queue
`default_nettype none
package rreq_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_W     = 16;
  localparam int CFG_W    = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic MODE_SERVE    = 1'b0;
  localparam logic MODE_EXPEDITE = 1'b1;

  // what a cell loads at the next edge
  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_RIGHT,
    SEL_LEFT,
    SEL_HEAD,
    SEL_NEW,
    SEL_FILL
  } cell_sel_t;

  typedef struct packed {
    cell_sel_t         sel;
    logic [ID_W-1:0]   cmd_id;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* src/rreq_cell.sv */
// one list slot: holds an id, shifts with its neighbors, compares to the command id
`default_nettype none
module rreq_cell
  import rreq_pkg::*;
(
  input  logic            clk,
  input  cell_ctl_t       ctl,
  input  logic [ID_W-1:0] left_id,
  input  logic [ID_W-1:0] right_id,
  input  logic [ID_W-1:0] head_id,
  input  logic [ID_W-1:0] fill_id,
  output logic [ID_W-1:0] value,
  output logic            match
);

  // slot register and registered compare
  always_ff @(posedge clk) begin
    unique case (ctl.sel)
      SEL_HOLD:  value <= value;
      SEL_RIGHT: value <= right_id;
      SEL_LEFT:  value <= left_id;
      SEL_HEAD:  value <= head_id;
      SEL_NEW:   value <= ctl.cmd_id;
      SEL_FILL:  value <= fill_id;
      default:   value <= value;
    endcase
    match <= (value == ctl.cmd_id);
  end

endmodule
`default_nettype wire

/* src/round_robin_expedite_queue_core.sv */
// top level: service list as a row of cells with its command sequencer
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------
//   in       | in_valid / in_ready   | mode, id
//   out      | out_valid / out_ready | served_id, dropped
//   cfg      | cfg_valid / cfg_ready | initial_count
//
// Every command passes through accept, compare in all cells, prefix of the
// hits, then at most one shift of the cell row. The cell row is the only
// resource. A serve waits in its last step while the previous item sits
// unread in the output register. Reset empties the list and clears the drop
// flag at once; a configuration write is taken only between commands and
// refills the whole row.
`default_nettype none
module round_robin_expedite_queue_core
  import rreq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  logic [ID_W-1:0]  id,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ID_W-1:0]  served_id,
  output logic             dropped,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] initial_count
);

  typedef enum logic [1:0] {ST_IDLE, ST_MATCH, ST_ORDER, ST_APPLY} state_t;

  state_t              state;
  logic                cmd_mode;
  logic [ID_W-1:0]     cmd_id;
  logic [CNT_W-1:0]    count;
  logic                drop;
  logic [CAPACITY-1:0] prior;
  logic                any_hit;

  logic [ID_W-1:0]     cell_val [CAPACITY];
  logic [CAPACITY-1:0] match_v;
  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] prior_next;
  cell_ctl_t           ctl [CAPACITY];

  logic                cfg_fire;
  logic                apply_go;
  logic                take_new;
  logic                full;
  logic [CNT_W-1:0]    fill_count;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign apply_go  = (state == ST_APPLY) &&
                     ((cmd_mode == MODE_EXPEDITE) || !out_valid || out_ready);
  assign take_new  = (cmd_mode == MODE_EXPEDITE) && (any_hit || !full);
  assign fill_count = (int'(initial_count) > CAPACITY) ? CNT_W'(CAPACITY)
                                                       : CNT_W'(initial_count);

  // cell row with per-slot control
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CAPACITY-1:0] LOW_MASK =
      (CAPACITY'(1) << i) - CAPACITY'(1);
    logic [ID_W-1:0] left_id;
    logic [ID_W-1:0] right_id;

    if (i == 0) begin : g_first
      assign left_id = '0;
    end else begin : g_inner_l
      assign left_id = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_id = '0;
    end else begin : g_inner_r
      assign right_id = cell_val[i+1];
    end

    // only slots inside the list may hit; earlier hit decides the shift
    assign hit[i]        = match_v[i] && (i < int'(count));
    assign prior_next[i] = |(hit & LOW_MASK);

    always_comb begin
      ctl[i].cmd_id = cmd_id;
      ctl[i].sel    = SEL_HOLD;
      if (cfg_fire) begin
        ctl[i].sel = SEL_FILL;
      end else if (apply_go && (cmd_mode == MODE_SERVE) && (count != '0)) begin
        if (i + 1 < int'(count)) begin
          ctl[i].sel = SEL_RIGHT;
        end else if (i + 1 == int'(count)) begin
          ctl[i].sel = SEL_HEAD;
        end
      end else if (apply_go && take_new) begin
        if (i == 0) begin
          ctl[i].sel = SEL_NEW;
        end else if (!prior[i] && (i <= int'(count))) begin
          ctl[i].sel = SEL_LEFT;
        end
      end
    end

    rreq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .left_id  (left_id),
      .right_id (right_id),
      .head_id  (cell_val[0]),
      .fill_id  (ID_W'(i + 1)),
      .value    (cell_val[i]),
      .match    (match_v[i])
    );
  end

  // sequencer, list count, drop flag and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      drop      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // output register: loaded by a serve, emptied by the receiver
      if (apply_go && (cmd_mode == MODE_SERVE)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_mode <= mode;
            cmd_id   <= id;
            state    <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          state <= ST_ORDER;
        end
        ST_ORDER: begin
          prior   <= prior_next;
          any_hit <= |hit;
          state   <= ST_APPLY;
        end
        ST_APPLY: begin
          if (apply_go) begin
            state <= ST_IDLE;
            if (cmd_mode == MODE_SERVE) begin
              served_id <= (count != '0) ? cell_val[0] : '0;
              dropped   <= drop;
            end else if (!any_hit) begin
              if (full) begin
                drop <= 1'b1;
              end else begin
                count <= count + CNT_W'(1);
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_fire) begin
        count <= fill_count;
      end
    end
  end

endmodule
`default_nettype wire

/* src/rreq_checker.sv */
// port-level checks of the expedite queue, bound to the top level
`default_nettype none
`include "round_robin_expedite_queue_core_macros.svh"
module rreq_checker
  import rreq_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ID_W-1:0]  served_id,
  input logic             dropped,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  logic seen_drop;

  // remember that a delivered item reported a drop
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_drop <= 1'b0;
    end else if (out_valid && out_ready && dropped) begin
      seen_drop <= 1'b1;
    end
  end

  `RREQ_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(served_id) && $stable(dropped), "stalled result changed")
  `RREQ_ASSERT_IMP(a_drop_sticky, clk, rst, out_valid && seen_drop,
    dropped, "drop flag fell without reset")
  `RREQ_ASSERT_NXT(a_one_at_a_time, clk, rst, in_valid && in_ready,
    !in_ready, "second item taken while one is at work")
  `RREQ_ASSERT_IMP(a_cfg_idle, clk, rst, cfg_valid && cfg_ready,
    in_ready, "configuration write taken during a command")

endmodule

bind round_robin_expedite_queue_core rreq_checker u_rreq_checker (.*);
`default_nettype wire
